/* src/morse_encoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef MORSE_ENCODER_ASSERT_SVH
`define MORSE_ENCODER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define MC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("morse_encoder: same-cycle check failed");

// Next-cycle implication, held off during reset
`define MC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("morse_encoder: next-cycle check failed");

`endif

/* src/mc_pkg.sv */
// ----------------------------------------------------------------------------
// mc_pkg
// Types, symbol codes and the Morse lookup table for the encoder.
// ----------------------------------------------------------------------------
package mc_pkg;

    localparam int CODE_MAX = 6;
    localparam int LEN_W    = $clog2(CODE_MAX + 1);

    typedef enum logic [1:0] {
        SYM_DOT   = 2'd0,
        SYM_DASH  = 2'd1,
        SYM_SLASH = 2'd2,
        SYM_SEP   = 2'd3
    } sym_t;

    // One decoded character: pattern is left-justified, dash = 1
    typedef struct packed {
        logic             slash;
        logic [LEN_W-1:0] len;
        logic [CODE_MAX-1:0] pattern;
    } code_t;

    typedef struct packed {
        logic  hit;
        code_t code;
    } lookup_t;

    function automatic lookup_t mk(input logic [LEN_W-1:0] len,
                                   input logic [CODE_MAX-1:0] pattern);
        lookup_t r;
        r.hit          = 1'b1;
        r.code.slash   = 1'b0;
        r.code.len     = len;
        r.code.pattern = pattern;
        return r;
    endfunction

    // Look up a lower-case character; a miss gives hit = 0
    function automatic lookup_t morse_lookup(input logic [7:0] ch);
        lookup_t r;
        r = '0;
        case (ch)
            8'h61: r = mk(3'd2, 6'b010000); // a
            8'h62: r = mk(3'd4, 6'b100000);
            8'h63: r = mk(3'd4, 6'b101000);
            8'h64: r = mk(3'd3, 6'b100000);
            8'h65: r = mk(3'd1, 6'b000000);
            8'h66: r = mk(3'd4, 6'b001000);
            8'h67: r = mk(3'd3, 6'b110000);
            8'h68: r = mk(3'd4, 6'b000000);
            8'h69: r = mk(3'd2, 6'b000000);
            8'h6a: r = mk(3'd4, 6'b011100);
            8'h6b: r = mk(3'd3, 6'b101000);
            8'h6c: r = mk(3'd4, 6'b010000);
            8'h6d: r = mk(3'd2, 6'b110000);
            8'h6e: r = mk(3'd2, 6'b100000);
            8'h6f: r = mk(3'd3, 6'b111000);
            8'h70: r = mk(3'd4, 6'b011000);
            8'h71: r = mk(3'd4, 6'b110100);
            8'h72: r = mk(3'd3, 6'b010000);
            8'h73: r = mk(3'd3, 6'b000000);
            8'h74: r = mk(3'd1, 6'b100000);
            8'h75: r = mk(3'd3, 6'b001000);
            8'h76: r = mk(3'd4, 6'b000100);
            8'h77: r = mk(3'd3, 6'b011000);
            8'h78: r = mk(3'd4, 6'b100100);
            8'h79: r = mk(3'd4, 6'b101100);
            8'h7a: r = mk(3'd4, 6'b110000); // z
            8'h30: r = mk(3'd5, 6'b111110); // 0
            8'h31: r = mk(3'd5, 6'b011110);
            8'h32: r = mk(3'd5, 6'b001110);
            8'h33: r = mk(3'd5, 6'b000110);
            8'h34: r = mk(3'd5, 6'b000010);
            8'h35: r = mk(3'd5, 6'b000000);
            8'h36: r = mk(3'd5, 6'b100000);
            8'h37: r = mk(3'd5, 6'b110000);
            8'h38: r = mk(3'd5, 6'b111000);
            8'h39: r = mk(3'd5, 6'b111100); // 9
            8'h20:
            begin
                // word gap: three slashes
                r = mk(3'd3, 6'b000000);
                r.code.slash = 1'b1;
            end
            8'h2e: r = mk(3'd6, 6'b010101); // .
            8'h2c: r = mk(3'd6, 6'b110011); // ,
            8'h3a: r = mk(3'd6, 6'b111000); // :
            8'h3f: r = mk(3'd6, 6'b001100); // ?
            8'h2d: r = mk(3'd6, 6'b100001); // -
            8'h2f: r = mk(3'd5, 6'b100100); // /
            8'h40: r = mk(3'd6, 6'b011010); // @
            8'h3d: r = mk(3'd5, 6'b100010); // =
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* src/mc_front.sv */
// ----------------------------------------------------------------------------
// mc_front
// Accepts characters, folds case, looks up the code and queues hits.
// ----------------------------------------------------------------------------
module mc_front
    import mc_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] character,
    input  logic       q_full,
    output logic       q_push,
    output code_t      q_entry
);

    logic [7:0] folded;
    lookup_t    look;

    // Fold upper case to lower case
    always_comb
    begin
        folded = character;
        if (character inside {[8'd65:8'd90]})
        begin
            folded = character + 8'd32;
        end
    end

    assign look     = morse_lookup(folded);

    // Drop misses; queue hits
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && look.hit;
    assign q_entry  = look.code;

endmodule

/* src/mc_queue.sv */
// ----------------------------------------------------------------------------
// mc_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module mc_queue
    import mc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  code_t wr_data,
    input  logic  pop,
    output code_t rd_data,
    output logic  full,
    output logic  empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    code_t             mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/mc_back.sv */
// ----------------------------------------------------------------------------
// mc_back
// Sends a queued code, one symbol per cycle unless stalled, then a separator.
// ----------------------------------------------------------------------------
module mc_back
    import mc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  code_t       q_entry,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  symbol,
    output logic        last
);

    localparam logic [LEN_W-1:0] TOP_BIT = LEN_W'(CODE_MAX - 1);

    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    sym_t             sym_reg, sym_next;
    logic             last_reg, last_next;
    logic             advance;
    logic [LEN_W-1:0] bit_sel;

    assign advance = !valid_reg || !out_stall;
    assign bit_sel = TOP_BIT - idx_reg;

    // Pick the next symbol of the head entry
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (advance)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                if (idx_reg == q_entry.len)
                begin
                    sym_next  = SYM_SEP;
                    last_next = 1'b1;
                    idx_next  = '0;
                    q_pop     = 1'b1;
                end
                else
                begin
                    if (q_entry.slash)
                    begin
                        sym_next = SYM_SLASH;
                    end
                    else if (q_entry.pattern[bit_sel])
                    begin
                        sym_next = SYM_DASH;
                    end
                    else
                    begin
                        sym_next = SYM_DOT;
                    end
                    last_next = 1'b0;
                    idx_next  = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        sym_reg  <= sym_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign symbol    = sym_reg;
    assign last      = last_reg;

endmodule

/* src/morse_encoder.sv */
// ----------------------------------------------------------------------------
// morse_encoder: ASCII to Morse symbol stream
// Path: an accepted character is queued, then its first symbol is registered.
// Serialiser: a code of n symbols (1 to 6) is sent, then a separator.
// Reset: asynchronous, clears the queue and output valid; no item in flight.
// ----------------------------------------------------------------------------
module morse_encoder
    import mc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] symbol,
    output logic       last
);

    code_t push_entry, head_entry;
    logic  push, pop, full, empty;

    // Classify requests
    mc_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .character (character),
        .q_full    (full),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    // Decouple front and back
    mc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_entry),
        .pop     (pop),
        .rd_data (head_entry),
        .full    (full),
        .empty   (empty)
    );

    // Emit symbols
    mc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_entry   (head_entry),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .last      (last)
    );

endmodule

/* src/mc_checker.sv */
// ----------------------------------------------------------------------------
// mc_checker
// Port-level checks on the encoder's symbol stream.
// ----------------------------------------------------------------------------
`include "morse_encoder_assert.svh"

module mc_checker
    import mc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] symbol,
    input logic       last
);

    logic out_take;
    logic out_held;
    logic out_mark;
    logic out_slash;

    assign out_take  = out_valid && !out_stall;
    assign out_held  = out_valid && out_stall;
    assign out_mark  = out_take && (symbol == SYM_DOT || symbol == SYM_DASH);
    assign out_slash = out_valid && (symbol == SYM_SLASH);

    // A stalled result holds
    `MC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(symbol) && $stable(last))

    // The last flag marks exactly the separator
    `MC_ASSERT_SAME(a_last_sep, clk, rst_n, out_valid, last == (symbol == SYM_SEP))

    // A slash never follows a dot or a dash within one code
    `MC_ASSERT_NEXT(a_no_mixed, clk, rst_n, out_mark, !out_slash)

endmodule

bind morse_encoder mc_checker u_mc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
);
